[design/srs_pkg.sv]
package srs_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 16;
	localparam int REC_W = KEY_W + TAG_W;

	// record as it sits in the stores: key in the low bits, tag above it
	typedef logic [REC_W-1:0] rec_t;

	function automatic logic key_le(input rec_t x, input rec_t y);
		key_le = $signed(x[KEY_W-1:0]) <= $signed(y[KEY_W-1:0]);
	endfunction

endpackage

[design/srs_ram.sv]
module srs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/stable_record_sorter.sv]
// stable_record_sorter: stable ascending merge sort of a batch of records.
// The slave channel takes one record per transaction (key in tdata[31:0],
// tag in tdata[47:32]); tlast marks the final record of the batch. Records
// past MAX_ITEMS are dropped and the batch is flagged as overflowed.
// After the last record the block sorts bottom-up, merging runs between two
// single-port-read RAMs in ping-pong fashion, then streams every record out
// on the master channel in ascending key order; records with equal keys keep
// their arrival order. m_tlast marks the final record, m_tuser the overflow.
// Loading accepts one record per cycle. Sorting takes ceil(log2 n) passes;
// in a pass each merge step writes one record and, until its run pair is
// done, refills one head register through the RAM read port. Emission
// reads each record, registers it and holds it until the sink accepts it.
// s_tready is high only while loading, so a batch is fully sorted and sent
// before the next one is taken. A stalled sink simply holds the output
// register and the sequencer waits. Reset clears the counters and returns the
// block to loading; the RAMs need no clearing as every entry used was written.
module stable_record_sorter
	import srs_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [REC_W-1:0]  s_tdata,   // sort_key, record_tag
	input  logic              s_tlast,   // last_item
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [REC_W-1:0]  m_tdata,   // sorted_key, sorted_tag
	output logic              m_tlast,   // last_result
	output logic              m_tuser    // overflow
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int PW = CW + 2;

	typedef enum logic [3:0] {
		ST_LOAD, ST_PAIR, ST_RD_A, ST_RD_B, ST_CAP_B, ST_MERGE, ST_FILL,
		ST_EMIT_RD, ST_EMIT_CAP, ST_EMIT_OUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [PW-1:0] n_q, w_q, lo_q, mid_q, hi_q, a_q, b_q, k_q, i_q;
	logic          sel_q;
	logic          from_a_q;
	rec_t          ha_q, hb_q;
	rec_t          out_q;
	logic          out_valid_q, out_last_q, out_ovf_q;

	logic          in_acc, has_room, take_a;
	logic [PW-1:0] n_new, lo_w, lo_2w, w_2;
	logic [PW-1:0] raddr;
	rec_t          rdata, rd0, rd1, wdata;
	logic          we0, we1;
	logic [PW-1:0] waddr;

	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign has_room = cnt_q < CW'(MAX_ITEMS);
	assign n_new    = PW'(cnt_q) + PW'(has_room);
	assign lo_w     = lo_q + w_q;
	assign w_2      = w_q << 1;
	assign lo_2w    = lo_q + w_2;
	assign rdata    = sel_q ? rd1 : rd0;
	assign take_a   = (a_q < mid_q) && ((b_q >= hi_q) || key_le(ha_q, hb_q));

	always_comb begin
		raddr = a_q;
		unique case (state_q)
			ST_RD_B:                 raddr = b_q;
			ST_MERGE:                raddr = take_a ? a_q + PW'(1) : b_q + PW'(1);
			ST_EMIT_RD:              raddr = i_q;
			default:                 raddr = a_q;
		endcase
	end

	// loading fills ram 0; a merge step writes the destination of this pass
	always_comb begin
		we0   = 1'b0;
		we1   = 1'b0;
		waddr = k_q;
		wdata = take_a ? ha_q : hb_q;
		if (state_q == ST_LOAD) begin
			we0   = in_acc && has_room;
			waddr = PW'(cnt_q);
			wdata = s_tdata;
		end else if (state_q == ST_MERGE) begin
			we0 = sel_q;
			we1 = !sel_q;
		end
	end

	srs_ram #(.WIDTH(REC_W), .DEPTH(MAX_ITEMS)) u_ram0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr[AW-1:0]),
		.rdata (rd0)
	);

	srs_ram #(.WIDTH(REC_W), .DEPTH(MAX_ITEMS)) u_ram1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr[AW-1:0]),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			w_q         <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			sel_q       <= 1'b0;
			from_a_q    <= 1'b0;
			ha_q        <= '0;
			hb_q        <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							n_q   <= n_new;
							w_q   <= PW'(1);
							lo_q  <= '0;
							i_q   <= '0;
							sel_q <= 1'b0;
							state_q <= (n_new > PW'(1)) ? ST_PAIR : ST_EMIT_RD;
						end
					end
				end
				ST_PAIR: begin
					// a short tail run becomes a plain copy with an empty right run
					a_q   <= lo_q;
					k_q   <= lo_q;
					mid_q <= (lo_w < n_q) ? lo_w : n_q;
					b_q   <= (lo_w < n_q) ? lo_w : n_q;
					hi_q  <= (lo_2w < n_q) ? lo_2w : n_q;
					state_q <= ST_RD_A;
				end
				ST_RD_A: begin
					state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					ha_q    <= rdata;
					state_q <= ST_CAP_B;
				end
				ST_CAP_B: begin
					hb_q    <= rdata;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					from_a_q <= take_a;
					k_q      <= k_q + PW'(1);
					if (take_a) begin
						a_q <= a_q + PW'(1);
					end else begin
						b_q <= b_q + PW'(1);
					end
					if (k_q + PW'(1) == hi_q) begin
						if (lo_2w < n_q) begin
							lo_q    <= lo_2w;
							state_q <= ST_PAIR;
						end else begin
							sel_q <= !sel_q;
							w_q   <= w_2;
							lo_q  <= '0;
							state_q <= (w_2 >= n_q) ? ST_EMIT_RD : ST_PAIR;
						end
					end else begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (from_a_q) begin
						ha_q <= rdata;
					end else begin
						hb_q <= rdata;
					end
					state_q <= ST_MERGE;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CAP;
				end
				ST_EMIT_CAP: begin
					out_q       <= rdata;
					out_last_q  <= (i_q + PW'(1) == n_q);
					out_ovf_q   <= ovf_q;
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							i_q     <= i_q + PW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	a_no_load_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input taken while a result is pending");

	a_no_write_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_OUT) |-> (!we0 && !we1))
		else $error("ram written during emission");

	a_merge_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (k_q < hi_q && hi_q <= n_q))
		else $error("merge write pointer outside its run pair");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("record count beyond capacity");

	a_single_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(we0 && we1))
		else $error("both rams written in one cycle");

endmodule
